@@ hdl/bpc_pkg.sv @@
// bpc_pkg: shared constants for the button press classifier
// phase codes, event bit positions, register indexes and port widths
// no dependencies
package bpc_pkg;

  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  typedef logic [PHASE_W-1:0] phase_t;

  // phase codes
  localparam phase_t PH_IDLE     = 3'd0;
  localparam phase_t PH_B1_COUNT = 3'd1;
  localparam phase_t PH_B1_LONG  = 3'd2;
  localparam phase_t PH_B1_WAIT  = 3'd3;
  localparam phase_t PH_B2_COUNT = 3'd4;
  localparam phase_t PH_B2_LONG  = 3'd5;
  localparam phase_t PH_B2_WAIT  = 3'd6;
  localparam phase_t PH_UNUSED   = 3'd7;

  // event bits within one button nibble
  localparam int unsigned EV_PRESSING = 0;
  localparam int unsigned EV_SHORT    = 1;
  localparam int unsigned EV_LONG     = 2;
  localparam int unsigned EV_RELEASED = 3;
  localparam int unsigned NIB_W       = 4;

  // register indexes
  typedef logic [CFG_ADDR_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_LONG_PRESS   = 2'd0;
  localparam cfg_idx_t REG_LONG_CONFIRM = 2'd1;
  localparam cfg_idx_t REG_REPEAT_WAIT  = 2'd2;
  localparam cfg_idx_t REG_TWO_BUTTONS  = 2'd3;

  localparam logic [CNT_W-1:0] RST_LONG_PRESS   = 8'd8;
  localparam logic [CNT_W-1:0] RST_LONG_CONFIRM = 8'd2;
  localparam logic [CNT_W-1:0] RST_REPEAT_WAIT  = 8'd8;

endpackage

@@ hdl/button_press_classifier.sv @@
// button_press_classifier: long-press and auto-repeat detector, one or two buttons
// input register, single-pass phase/countdown update, result register
// depends on bpc_pkg
//
// path: each input transaction is captured in the input register, then its result
//   is written to the result register; one tick per clock cycle while out_tready
//   allows, set by the single phase/countdown update
// reset: synchronous active-low rst_n clears both pipeline stages, phase, countdown
//   and code word, and loads the tick registers with 8, 2, 8 and two_buttons with 0
module button_press_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bpc_pkg::IN_DATA_W-1:0]      in_tdata,   // button1_down, button2_down,
                                                         // clear_code, zero fill
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bpc_pkg::OUT_DATA_W-1:0]     out_tdata,  // event_code[7:0], phase[10:8],
                                                         // zero fill
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [bpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [bpc_pkg::CNT_W-1:0] long_press_r;
  logic [bpc_pkg::CNT_W-1:0] long_confirm_r;
  logic [bpc_pkg::CNT_W-1:0] repeat_wait_r;
  logic                      two_buttons_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r   <= bpc_pkg::RST_LONG_PRESS;
      long_confirm_r <= bpc_pkg::RST_LONG_CONFIRM;
      repeat_wait_r  <= bpc_pkg::RST_REPEAT_WAIT;
      two_buttons_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        bpc_pkg::REG_LONG_PRESS:   long_press_r   <= cfg_wdata;
        bpc_pkg::REG_LONG_CONFIRM: long_confirm_r <= cfg_wdata;
        bpc_pkg::REG_REPEAT_WAIT:  repeat_wait_r  <= cfg_wdata;
        bpc_pkg::REG_TWO_BUTTONS:  two_buttons_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: the result register frees up when empty or being taken,
  // the input register moves on when it holds a tick and the result slot is free
  logic in_vld_r;
  logic out_vld_r;
  logic out_free;
  logic stage_adv;

  assign out_free   = !out_vld_r || out_tready;
  assign stage_adv  = in_vld_r && out_free;
  assign in_tready  = !in_vld_r || stage_adv;
  assign out_tvalid = out_vld_r;

  // input register (payload, no reset)
  logic b1_r;
  logic b2_r;
  logic clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      b1_r  <= in_tdata[0];
      b2_r  <= in_tdata[1];
      clr_r <= in_tdata[2];
    end
  end

  // classifier state
  bpc_pkg::phase_t           phase_r, phase_nxt;
  logic [bpc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [bpc_pkg::CODE_W-1:0] code_r, code_nxt;

  // working signals
  logic                       b1;
  logic                       b2;
  logic [bpc_pkg::CODE_W-1:0] code_lvl;      // code word after clear and level update
  logic                       sel_b2;        // active phase belongs to button 2
  bpc_pkg::phase_t            base;          // phase offset of the active button from button 1
  bpc_pkg::phase_t            sub;           // phase relative to the active button
  logic                       held;
  logic [bpc_pkg::CNT_W-1:0]  cnt_dec;
  logic [bpc_pkg::NIB_W-1:0]  nib_short;
  logic [bpc_pkg::NIB_W-1:0]  nib_long;
  logic [bpc_pkg::NIB_W-1:0]  nib_long_held;
  logic [bpc_pkg::CODE_W-1:0] code_short;
  logic [bpc_pkg::CODE_W-1:0] code_long;
  logic [bpc_pkg::CODE_W-1:0] code_long_held;
  logic [bpc_pkg::CODE_W-1:0] code_rel;

  always_comb begin
    b1 = b1_r;
    b2 = b2_r && two_buttons_r;   // second button ignored unless enabled

    code_lvl = clr_r ? '0 : code_r;
    code_lvl[bpc_pkg::EV_PRESSING]                  = b1;
    code_lvl[bpc_pkg::NIB_W + bpc_pkg::EV_PRESSING] = b2;

    sel_b2 = (phase_r >= bpc_pkg::PH_B2_COUNT);
    base   = sel_b2 ? (bpc_pkg::PH_B2_COUNT - bpc_pkg::PH_B1_COUNT) : bpc_pkg::PH_IDLE;
    sub    = phase_r - base;
    held   = sel_b2 ? b2 : b1;
    cnt_dec = cnt_r - 1'b1;

    nib_short     = '0;
    nib_long      = '0;
    nib_short[bpc_pkg::EV_SHORT]        = 1'b1;
    nib_short[bpc_pkg::EV_RELEASED]     = 1'b1;
    nib_long[bpc_pkg::EV_LONG]          = 1'b1;
    nib_long[bpc_pkg::EV_RELEASED]      = 1'b1;
    nib_long_held                       = nib_long;
    nib_long_held[bpc_pkg::EV_PRESSING] = 1'b1;

    // events land in the active button's nibble and replace the whole word
    code_short     = sel_b2 ? {nib_short, 4'b0}     : {4'b0, nib_short};
    code_long      = sel_b2 ? {nib_long, 4'b0}      : {4'b0, nib_long};
    code_long_held = sel_b2 ? {nib_long_held, 4'b0} : {4'b0, nib_long_held};

    // release from the wait phase only drops the pressing bit, already done by
    // the level update
    code_rel = code_lvl;

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    code_nxt  = code_lvl;

    unique case (phase_r)
      bpc_pkg::PH_IDLE: begin
        // button 2 wins when both go down together
        if (b1) begin
          cnt_nxt   = long_press_r;
          phase_nxt = bpc_pkg::PH_B1_COUNT;
        end
        if (b2) begin
          cnt_nxt   = long_press_r;
          phase_nxt = bpc_pkg::PH_B2_COUNT;
        end
      end
      bpc_pkg::PH_B1_COUNT, bpc_pkg::PH_B1_LONG, bpc_pkg::PH_B1_WAIT,
      bpc_pkg::PH_B2_COUNT, bpc_pkg::PH_B2_LONG, bpc_pkg::PH_B2_WAIT: begin
        if (!held) begin
          phase_nxt = bpc_pkg::PH_IDLE;
          case (sub)
            bpc_pkg::PH_B1_COUNT: code_nxt = code_short;
            bpc_pkg::PH_B1_LONG:  code_nxt = code_long;
            default:              code_nxt = code_rel;
          endcase
        end else begin
          cnt_nxt = cnt_dec;   // zero setting wraps to a 256 tick phase
          if (cnt_dec == '0) begin
            case (sub)
              bpc_pkg::PH_B1_LONG: begin
                code_nxt  = code_long_held;
                cnt_nxt   = repeat_wait_r;
                phase_nxt = base + bpc_pkg::PH_B1_WAIT;
              end
              default: begin
                // count expiry and repeat expiry both head for the long phase
                cnt_nxt   = long_confirm_r;
                phase_nxt = base + bpc_pkg::PH_B1_LONG;
              end
            endcase
          end
        end
      end
      default: begin
        // unused code: back to idle, code word keeps its level update
        phase_nxt = bpc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bpc_pkg::PH_IDLE;
      cnt_r   <= '0;
      code_r  <= '0;
    end else if (stage_adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      code_r  <= code_nxt;
    end
  end

  // result register: mirrors the state just written
  logic [bpc_pkg::CODE_W-1:0] ev_out_r;
  bpc_pkg::phase_t            ph_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      ev_out_r <= code_nxt;
      ph_out_r <= phase_nxt;
    end
  end

  assign out_tdata = {5'b0, ph_out_r, ev_out_r};

endmodule

@@ hdl/bpc_checker.sv @@
// bpc_checker: port-level assertions for the button press classifier
// bound to button_press_classifier, depends on bpc_pkg
// checks result transactions only through the top level's ports
module bpc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bpc_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [bpc_pkg::PHASE_W-1:0] ph;
  assign ph = out_tdata[10:8];

  // stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing is presented right after a reset cycle
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // unused phase code never leaves the block, fill bits stay zero
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ph != bpc_pkg::PH_UNUSED) && (out_tdata[15:11] == '0))
    else $error("bad phase or fill bits");

  // an active button 1 phase means button 1 is still down
  a_b1_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (ph == bpc_pkg::PH_B1_COUNT || ph == bpc_pkg::PH_B1_LONG ||
                   ph == bpc_pkg::PH_B1_WAIT) |-> out_tdata[bpc_pkg::EV_PRESSING])
    else $error("button 1 phase without pressing bit");

  // an active button 2 phase means button 2 is still down
  a_b2_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (ph == bpc_pkg::PH_B2_COUNT || ph == bpc_pkg::PH_B2_LONG ||
                   ph == bpc_pkg::PH_B2_WAIT) |->
      out_tdata[bpc_pkg::NIB_W + bpc_pkg::EV_PRESSING])
    else $error("button 2 phase without pressing bit");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
